// ===== sv/tap_block_framer_defines.svh =====
// assertion macros shared by the checker
`ifndef TAP_BLOCK_FRAMER_DEFINES_SVH
`define TAP_BLOCK_FRAMER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define TBF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define TBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tbf_pkg.sv =====
package tbf_pkg;

  // default limits of the block
  localparam int unsigned MaxIdLenDef = 16;
  localparam int unsigned FrameMaxDef = 256;

  // bytes of framing that count against the frame size
  localparam int unsigned TrailerLen = 8;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 4;

  // control characters
  localparam logic [7:0] ChStx    = 8'h02;
  localparam logic [7:0] ChEtx    = 8'h03;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChDigit0 = 8'h30;

  // frame phase as seen by the front
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhId   = 2'd1,
    PhMsg  = 2'd2
  } phase_e;

  // position inside the message trailer
  typedef enum logic [2:0] {
    TailMsgCr = 3'd0,
    TailEtx   = 3'd1,
    TailCkHi  = 3'd2,
    TailCkMid = 3'd3,
    TailCkLo  = 3'd4,
    TailEndCr = 3'd5
  } tail_step_e;

  // output steps one request asks for, emitted in this order
  typedef struct packed {
    logic stx;
    logic dat;
    logic idcr;
    logic tail;
  } step_mask_t;

  // command from front to back
  typedef struct packed {
    logic [7:0] data;
    step_mask_t steps;
    logic       trunc;
  } cmd_t;

endpackage

// ===== sv/tbf_front.sv =====
module tbf_front
  import tbf_pkg::*;
#(
  parameter int unsigned MAX_ID_LEN = MaxIdLenDef,
  parameter int unsigned FRAME_MAX  = FrameMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       part_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       empty_req_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned IdW  = $clog2(MAX_ID_LEN + 1);
  localparam int unsigned MsgW = $clog2(FRAME_MAX + 1);
  localparam int unsigned SumW = $clog2(FRAME_MAX + MAX_ID_LEN + TrailerLen + 1) + 1;

  phase_e          phase_q, phase_d;
  logic [IdW-1:0]  id_cnt_q, id_cnt_d;
  logic [MsgW-1:0] msg_cnt_q, msg_cnt_d;
  logic            drop_q, drop_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      id_cnt_q  <= '0;
      msg_cnt_q <= '0;
      drop_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      id_cnt_q  <= id_cnt_d;
      msg_cnt_q <= msg_cnt_d;
      drop_q    <= drop_d;
    end
  end

  // classify the request and update frame counters
  always_comb begin
    logic [IdW-1:0] id_base;
    logic           drop_now;
    logic [SumW-1:0] used;
    phase_d   = phase_q;
    id_cnt_d  = id_cnt_q;
    msg_cnt_d = msg_cnt_q;
    drop_d    = drop_q;
    cmd_o     = '0;
    cmd_o.data = data_i;
    id_base   = id_cnt_q;
    drop_now  = drop_q;
    used      = SumW'(msg_cnt_q) + SumW'(id_cnt_q) + SumW'(TrailerLen);
    if (accept_i && !(empty_req_i && !last_i)) begin
      unique case (phase_q)
        PhMsg: begin
          if (part_i) begin
            if (!empty_req_i) begin
              if (used < SumW'(FRAME_MAX)) begin
                msg_cnt_d       = msg_cnt_q + 1'b1;
                cmd_o.steps.dat = 1'b1;
              end else begin
                drop_now = 1'b1;
              end
            end
            drop_d = drop_now;
            if (last_i) begin
              // trailer closes the frame, back to reset state
              cmd_o.steps.tail = 1'b1;
              cmd_o.trunc      = drop_now;
              phase_d          = PhIdle;
              id_cnt_d         = '0;
              msg_cnt_d        = '0;
              drop_d           = 1'b0;
            end
          end
        end
        default: begin
          if (!part_i) begin
            if (phase_q != PhId) begin
              // first id request opens a new frame
              id_base         = '0;
              drop_now        = 1'b0;
              msg_cnt_d       = '0;
              cmd_o.steps.stx = 1'b1;
              phase_d         = PhId;
            end
            id_cnt_d = id_base;
            if (!empty_req_i) begin
              if (id_base < IdW'(MAX_ID_LEN)) begin
                id_cnt_d        = id_base + 1'b1;
                cmd_o.steps.dat = 1'b1;
              end else begin
                drop_now = 1'b1;
              end
            end
            drop_d = drop_now;
            if (last_i) begin
              cmd_o.steps.idcr = 1'b1;
              phase_d          = PhMsg;
            end
          end
        end
      endcase
    end
  end

  assign push_o = accept_i && (cmd_o.steps != '0);

endmodule

// ===== sv/tbf_queue.sv =====
module tbf_queue
  import tbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  // command storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);

endmodule

// ===== sv/tbf_back.sv =====
module tbf_back
  import tbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] m_byte_o,
  output logic       m_run_last_o,
  output logic       m_frame_end_o,
  output logic       m_trunc_o
);

  logic       busy_q, busy_d;
  step_mask_t mask_q, mask_d;
  tail_step_e tail_q, tail_d;
  logic [15:0] sum_q, sum_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       run_last_q, run_last_d;
  logic       frame_end_q, frame_end_d;
  logic       trunc_q, trunc_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      mask_q  <= '0;
      tail_q  <= TailMsgCr;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      mask_q  <= mask_d;
      tail_q  <= tail_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    run_last_q  <= run_last_d;
    frame_end_q <= frame_end_d;
    trunc_q     <= trunc_d;
  end

  // pick the next output step of the head command
  always_comb begin
    step_mask_t cur;
    step_mask_t nxt;
    logic [7:0] ob;
    logic       add;
    logic       fe;
    logic       fire;
    cur  = busy_q ? mask_q : head_i.steps;
    nxt  = cur;
    ob   = ChCr;
    add  = 1'b0;
    fe   = 1'b0;
    fire = !empty_i && (!valid_q || m_ready_i);

    busy_d      = busy_q;
    mask_d      = mask_q;
    tail_d      = tail_q;
    sum_d       = sum_q;
    valid_d     = valid_q;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    frame_end_d = frame_end_q;
    trunc_d     = trunc_q;
    pop_o       = 1'b0;

    priority if (cur.stx) begin
      ob      = ChStx;
      nxt.stx = 1'b0;
    end else if (cur.dat) begin
      ob      = head_i.data;
      add     = 1'b1;
      nxt.dat = 1'b0;
    end else if (cur.idcr) begin
      ob       = ChCr;
      add      = 1'b1;
      nxt.idcr = 1'b0;
    end else begin
      // message trailer with checksum digits
      unique case (tail_q)
        TailMsgCr: begin
          ob  = ChCr;
          add = 1'b1;
        end
        TailEtx: begin
          ob  = ChEtx;
          add = 1'b1;
        end
        TailCkHi:  ob = ChDigit0 + 8'(sum_q[11:8]);
        TailCkMid: ob = ChDigit0 + 8'(sum_q[7:4]);
        TailCkLo:  ob = ChDigit0 + 8'(sum_q[3:0]);
        default: begin
          ob       = ChCr;
          fe       = 1'b1;
          nxt.tail = 1'b0;
        end
      endcase
    end

    if (!valid_q || m_ready_i) begin
      valid_d = !empty_i;
    end

    if (fire) begin
      byte_d      = ob;
      frame_end_d = fe;
      trunc_d     = fe && head_i.trunc;
      run_last_d  = (nxt == '0);
      if (cur.stx) begin
        sum_d = 16'(ChStx);
      end else if (add) begin
        sum_d = sum_q + 16'(ob);
      end
      if (!cur.stx && !cur.dat && !cur.idcr) begin
        tail_d = fe ? TailMsgCr : tail_step_e'(tail_q + 3'd1);
      end
      if (nxt == '0) begin
        pop_o  = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        mask_d = nxt;
      end
    end
  end

  assign m_valid_o     = valid_q;
  assign m_byte_o      = byte_q;
  assign m_run_last_o  = run_last_q;
  assign m_frame_end_o = frame_end_q;
  assign m_trunc_o     = trunc_q;

endmodule

// ===== sv/tap_block_framer.sv =====
// Paging block framer. Requests carry recipient id bytes (tuser[0] = 0) and
// then message bytes (tuser[0] = 1); the block emits STX, the id (at most
// MAX_ID_LEN bytes), CR, the message (at most FRAME_MAX - id length - 8
// bytes), CR, ETX, three checksum digits and a final CR that carries
// frame_end and the truncated flag. A data byte request gives one output
// byte, so a stream of bytes runs at one request per cycle while the queue
// has room; the request that opens a frame or ends the id part gives
// up to three bytes, the one that ends the message up to seven. The front
// classifies each request in the cycle it is accepted and hands a command
// to a four-entry queue; the back emits one byte per cycle from its output
// register while a command waits and the output is not stalled, which sets
// the sustained rate. Requests giving no byte (wrong part, dropped bytes,
// empty non-last items) produce no output. No clearing pass after reset.
module tap_block_framer
  import tbf_pkg::*;
#(
  parameter int unsigned MAX_ID_LEN = MaxIdLenDef,
  parameter int unsigned FRAME_MAX  = FrameMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data
  input  logic       s_axis_tlast,
  input  logic [1:0] s_axis_tuser,   // [0] part, [1] empty_req
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [0] frame_end, [1] truncated
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t cmd;
  cmd_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: classify requests and track frame limits
  tbf_front #(
    .MAX_ID_LEN (MAX_ID_LEN),
    .FRAME_MAX  (FRAME_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .part_i      (s_axis_tuser[0]),
    .data_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .empty_req_i (s_axis_tuser[1]),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  // command queue
  tbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  // back: byte sequencer and checksum
  tbf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_byte_o      (m_axis_tdata),
    .m_run_last_o  (m_axis_tlast),
    .m_frame_end_o (m_axis_tuser[0]),
    .m_trunc_o     (m_axis_tuser[1])
  );

endmodule

// ===== sv/tbf_checker.sv =====
`include "tap_block_framer_defines.svh"

module tbf_checker
  import tbf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // stalled output holds its request
  `TBF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")

  // frame end is a final cr and closes the run
  `TBF_ASSERT(a_end_cr, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == ChCr), "frame end not on closing cr")

  // truncated flag only on frame end
  `TBF_ASSERT(a_trunc_end, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "truncated flag off frame end")

  // two frame ends cannot follow back to back
  `TBF_ASSERT_NEXT(a_no_double_end, m_axis_tvalid && m_axis_tready && m_axis_tuser[0], !(m_axis_tvalid && m_axis_tuser[0]), "frame end repeated")

endmodule

bind tap_block_framer tbf_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
